@@ rtl/core/ow_pkg.sv @@
package ow_pkg;

   // Operation codes carried by a request beat. Codes above OP_RBYTE act as ticks.
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_RESET = 3'd1;
   localparam logic [2:0] OP_WBIT  = 3'd2;
   localparam logic [2:0] OP_RBIT  = 3'd3;
   localparam logic [2:0] OP_WBYTE = 3'd4;
   localparam logic [2:0] OP_RBYTE = 3'd5;

   // Configuration register indexes.
   localparam logic [2:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [2:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [2:0] CSR_RECOVERY      = 3'd2;
   localparam logic [2:0] CSR_SHORT_SLOT    = 3'd3;
   localparam logic [2:0] CSR_LONG_SLOT     = 3'd4;

   // Reset values of the timing registers.
   localparam logic [11:0] RESET_LOW_DEFAULT     = 12'd500;
   localparam logic [11:0] PRESENCE_WAIT_DEFAULT = 12'd70;
   localparam logic [11:0] RECOVERY_DEFAULT      = 12'd500;
   localparam logic [11:0] SHORT_SLOT_DEFAULT    = 12'd7;
   localparam logic [11:0] LONG_SLOT_DEFAULT     = 12'd70;

   // Bit count of a byte command and of a bit command.
   localparam logic [3:0] BYTE_BITS = 4'd8;
   localparam logic [3:0] ONE_BIT   = 4'd1;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_WAIT = 4'd2,
      PH_RST_REC  = 4'd3,
      PH_WR_LOW   = 4'd4,
      PH_WR_HIGH  = 4'd5,
      PH_RD_LOW   = 4'd6,
      PH_RD_WAIT  = 4'd7,
      PH_RD_REC   = 4'd8
   } ow_phase_type;

   typedef struct packed {
      logic [11:0] reset_low_ticks;
      logic [11:0] presence_wait_ticks;
      logic [11:0] recovery_ticks;
      logic [11:0] short_slot_ticks;
      logic [11:0] long_slot_ticks;
   } ow_cfg_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] data_value;
      logic       bus_level;
   } ow_req_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic       bus_fault;
      logic [7:0] read_value;
      logic       rejected;
   } ow_rsp_type;

   // True for the write commands, which begin their slots in the write phases.
   function automatic logic is_write_kind(input logic [2:0] kind);
      return (kind == OP_WBIT) || (kind == OP_WBYTE);
   endfunction

endpackage

@@ rtl/core/one_wire_bus_master_top.sv @@
// Open-drain 1-Wire master paced by request beats: each beat is either a tick,
// which moves bus time on by one unit, or a command (reset, write bit, read bit,
// write byte, read byte), and each beat returns exactly one response beat that
// shows the drive level, busy, done, presence, fault, read data and reject flags.
// A beat is taken every clock cycle while the response side is not stalled by rsp_ready;
// the request is held in the request register and the response in the response
// register, and the whole phase, counter and shift update of the bus sequencer
// is combinational between them. Timing registers are written through the csr
// port, which is always ready; write them only while the block is idle.
module one_wire_bus_master_top
   import ow_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ow_req_type  req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ow_rsp_type  rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);

   ow_cfg_type cfg;
   ow_req_type req_ff;
   ow_rsp_type rsp_ff, step_rsp;
   logic       req_valid_ff, rsp_valid_ff, fire;

   assign csr_ready = 1'b1;

   ow_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // A held request beat moves on whenever the response register is free.
   assign fire      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || fire;

   ow_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (fire),
      .item    (req_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/ow_csr.sv @@
module ow_csr
   import ow_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   input  logic [2:0] csr_index,
   input  logic [11:0] csr_data,
   output ow_cfg_type cfg
);

   ow_cfg_type cfg_ff, cfg_in;

   // Decode the write index; unknown indexes leave every register as it is.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RESET_LOW:     cfg_in.reset_low_ticks     = csr_data;
            CSR_PRESENCE_WAIT: cfg_in.presence_wait_ticks = csr_data;
            CSR_RECOVERY:      cfg_in.recovery_ticks      = csr_data;
            CSR_SHORT_SLOT:    cfg_in.short_slot_ticks    = csr_data;
            CSR_LONG_SLOT:     cfg_in.long_slot_ticks     = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks     <= RESET_LOW_DEFAULT;
         cfg_ff.presence_wait_ticks <= PRESENCE_WAIT_DEFAULT;
         cfg_ff.recovery_ticks      <= RECOVERY_DEFAULT;
         cfg_ff.short_slot_ticks    <= SHORT_SLOT_DEFAULT;
         cfg_ff.long_slot_ticks     <= LONG_SLOT_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/ow_step.sv @@
module ow_step
   import ow_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  ow_req_type item,
   input  ow_cfg_type cfg,
   output ow_rsp_type rsp
);

   ow_phase_type phase_ff, phase_in, phase_now;
   logic [11:0]  tick_ff, tick_in;
   logic [3:0]   bits_ff, bits_in, bits_dec;
   logic [7:0]   shift_ff, shift_in;
   logic [2:0]   kind_ff, kind_in;
   logic         pres_ff, pres_in;
   logic         is_cmd, done, fault, rej, was_read;

   // Codes outside the phase list fall back to idle.
   always_comb begin
      unique case (phase_ff)
         PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC, PH_WR_LOW,
         PH_WR_HIGH, PH_RD_LOW, PH_RD_WAIT, PH_RD_REC: phase_now = phase_ff;
         default:                                      phase_now = PH_IDLE;
      endcase
   end

   assign is_cmd   = (item.operation >= OP_RESET) && (item.operation <= OP_RBYTE);
   assign bits_dec = bits_ff - ONE_BIT;

   // Next state for one beat: start a command, reject one while busy, or advance time by one tick.
   always_comb begin
      phase_in = phase_now;
      tick_in  = tick_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      kind_in  = kind_ff;
      pres_in  = pres_ff;
      done     = 1'b0;
      fault    = 1'b0;
      rej      = 1'b0;
      was_read = 1'b0;
      if (is_cmd && (phase_now != PH_IDLE)) begin
         rej = 1'b1;
      end else if (is_cmd) begin
         kind_in = item.operation;
         if (item.operation == OP_RESET) begin
            if (!item.bus_level) begin
               pres_in = 1'b0;
               fault   = 1'b1;
               done    = 1'b1;
            end else begin
               phase_in = PH_RST_LOW;
               tick_in  = cfg.reset_low_ticks;
            end
         end else begin
            bits_in = ((item.operation == OP_WBYTE) || (item.operation == OP_RBYTE)) ?
                      BYTE_BITS : ONE_BIT;
            if (item.operation == OP_WBYTE) begin
               shift_in = item.data_value;
            end else if (item.operation == OP_WBIT) begin
               shift_in = {7'd0, item.data_value[0]};
            end else begin
               shift_in = 8'd0;
            end
            if (is_write_kind(item.operation)) begin
               phase_in = PH_WR_LOW;
               tick_in  = shift_in[0] ? cfg.short_slot_ticks : cfg.long_slot_ticks;
            end else begin
               phase_in = PH_RD_LOW;
               tick_in  = cfg.short_slot_ticks;
            end
         end
      end else if (phase_now != PH_IDLE) begin
         if (tick_ff > 12'd1) begin
            tick_in = tick_ff - 12'd1;
         end else begin
            unique case (phase_now)
               PH_RST_LOW: begin
                  phase_in = PH_RST_WAIT;
                  tick_in  = cfg.presence_wait_ticks;
               end
               PH_RST_WAIT: begin
                  pres_in  = ~item.bus_level;
                  phase_in = PH_RST_REC;
                  tick_in  = cfg.recovery_ticks;
               end
               PH_RST_REC: begin
                  phase_in = PH_IDLE;
                  tick_in  = 12'd0;
                  done     = 1'b1;
               end
               PH_WR_LOW: begin
                  phase_in = PH_WR_HIGH;
                  tick_in  = shift_ff[0] ? cfg.long_slot_ticks : cfg.short_slot_ticks;
               end
               PH_RD_LOW: begin
                  phase_in = PH_RD_WAIT;
                  tick_in  = cfg.short_slot_ticks;
               end
               PH_RD_WAIT: begin
                  if (kind_ff == OP_RBIT) begin
                     shift_in = {7'd0, item.bus_level};
                  end else begin
                     shift_in = {item.bus_level, shift_ff[7:1]};
                  end
                  phase_in = PH_RD_REC;
                  tick_in  = cfg.long_slot_ticks;
               end
               PH_WR_HIGH, PH_RD_REC: begin
                  // End of a slot: the write slot shifts out its bit first.
                  if (phase_now == PH_WR_HIGH) begin
                     shift_in = {1'b0, shift_ff[7:1]};
                  end
                  bits_in = bits_dec;
                  if (bits_dec == 4'd0) begin
                     phase_in = PH_IDLE;
                     tick_in  = 12'd0;
                     done     = 1'b1;
                     was_read = (phase_now == PH_RD_REC);
                  end else if (is_write_kind(kind_ff)) begin
                     phase_in = PH_WR_LOW;
                     tick_in  = shift_in[0] ? cfg.short_slot_ticks : cfg.long_slot_ticks;
                  end else begin
                     phase_in = PH_RD_LOW;
                     tick_in  = cfg.short_slot_ticks;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Result fields follow the state that this beat leaves behind.
   always_comb begin
      rsp.drive_low  = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW) ||
                       (phase_in == PH_RD_LOW);
      rsp.busy_res   = (phase_in != PH_IDLE);
      rsp.done_res   = done;
      rsp.presence   = pres_in;
      rsp.bus_fault  = fault;
      rsp.read_value = was_read ? shift_in : 8'd0;
      rsp.rejected   = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= 12'd0;
         bits_ff  <= 4'd0;
         shift_ff <= 8'd0;
         kind_ff  <= OP_TICK;
         pres_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
         kind_ff  <= kind_in;
         pres_ff  <= pres_in;
      end
   end

endmodule
